>>> rtl/odo_pkg.sv
// ============================================================================
// Differential-drive odometry package
// Shared constants, types and the arctangent table for the pose integrator.
// ============================================================================
package odo_pkg;

    localparam int DATA_W     = 32;
    localparam int CNT_W      = 16;
    localparam int HEAD_W     = 16;
    localparam int CFG_AW     = 2;
    localparam int IDX_W      = 6;
    localparam int ATAN_N     = 24;
    localparam int DIV_STEPS  = 56;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [CFG_AW-1:0] REG_MPC  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_AXLE = 2'd1;

    localparam logic [31:0] MPC_RST  = 32'd4294967;
    localparam logic [31:0] AXLE_RST = 32'd65536;

    // round(2^32 / pi) and the CORDIC inverse gain in Q1.30.
    localparam logic [30:0] INV_PI_Q32  = 31'd1367130551;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SUM,
        MUL_DIFF,
        MUL_PLO,
        MUL_PHI,
        MUL_X,
        MUL_Y
    } t_mul_op;

    typedef struct packed {
        logic             load_in;
        t_mul_op          mul_op;
        logic             div_step;
        logic             turn;
        logic             cordic_init;
        logic             cordic_step;
        logic             cordic_fix;
        logic             update;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // Arctangent of 2^-i in 32-bit binary angle units.
    function automatic logic [29:0] atan_bam(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/odo_ctrl.sv
// ============================================================================
// Odometry controller
// Sequences the multiplier, divider and CORDIC steps for one transaction.
// ============================================================================
module odo_ctrl #(
    parameter int CORDIC_STAGES = odo_pkg::CORDIC_STAGES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output odo_pkg::t_cmd o_cmd
);
    import odo_pkg::*;

    localparam int NSTG = (CORDIC_STAGES > ATAN_N) ? ATAN_N : CORDIC_STAGES;

    typedef enum logic [3:0] {
        S_IDLE, S_MSUM, S_MDIFF, S_DIV, S_MPLO, S_MPHI, S_TURN,
        S_CINIT, S_CROT, S_CFIX, S_MX, S_MY, S_DONE
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_cnt;
    logic             r_in_stall;
    logic             r_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd             = '0;
        o_cmd.mul_op      = MUL_NONE;
        o_cmd.idx         = r_cnt;
        case (r_state)
            S_IDLE:  o_cmd.load_in     = i_in_valid;
            S_MSUM:  o_cmd.mul_op      = MUL_SUM;
            S_MDIFF: o_cmd.mul_op      = MUL_DIFF;
            S_DIV:   o_cmd.div_step    = 1'b1;
            S_MPLO:  o_cmd.mul_op      = MUL_PLO;
            S_MPHI:  o_cmd.mul_op      = MUL_PHI;
            S_TURN:  o_cmd.turn        = 1'b1;
            S_CINIT: o_cmd.cordic_init = 1'b1;
            S_CROT:  o_cmd.cordic_step = 1'b1;
            S_CFIX:  o_cmd.cordic_fix  = 1'b1;
            S_MX:    o_cmd.mul_op      = MUL_X;
            S_MY:    o_cmd.mul_op      = MUL_Y;
            S_DONE:  o_cmd.update      = out_free;
            default: o_cmd.mul_op      = MUL_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result replaces the old one in the cycle the old one leaves.
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_MSUM;
                        r_in_stall <= 1'b1;
                    end
                end
                S_MSUM:  r_state <= S_MDIFF;
                S_MDIFF: begin
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                end
                S_DIV: begin
                    if (r_cnt == IDX_W'(DIV_STEPS - 1)) begin
                        r_state <= S_MPLO;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MPLO:  r_state <= S_MPHI;
                S_MPHI:  r_state <= S_TURN;
                S_TURN:  r_state <= S_CINIT;
                S_CINIT: begin
                    r_state <= S_CROT;
                    r_cnt   <= '0;
                end
                S_CROT: begin
                    if (r_cnt == IDX_W'(NSTG - 1)) begin
                        r_state <= S_CFIX;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CFIX:  r_state <= S_MX;
                S_MX:    r_state <= S_MY;
                S_MY:    r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_in_stall  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/odo_dp.sv
// ============================================================================
// Odometry datapath
// Shared multiplier, radix-2 divider, iterative CORDIC and pose registers.
// ============================================================================
module odo_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  odo_pkg::t_cmd                i_cmd,
    input  logic                         i_cfg_we,
    input  logic [odo_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [odo_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic signed [odo_pkg::CNT_W-1:0] i_left_counts,
    input  logic signed [odo_pkg::CNT_W-1:0] i_right_counts,
    output logic signed [odo_pkg::DATA_W-1:0] o_x_pos,
    output logic signed [odo_pkg::DATA_W-1:0] o_y_pos,
    output logic signed [odo_pkg::HEAD_W-1:0] o_heading
);
    import odo_pkg::*;

    logic [31:0]        r_mpc, r_axle;
    logic signed [15:0] r_l, r_r;
    logic signed [32:0] r_dist;
    logic               r_neg;
    logic [31:0]        r_rem;
    logic [55:0]        r_qsh;
    logic [63:0]        r_plo;
    logic [35:0]        r_phi;
    logic [31:0]        r_turn, r_half;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_flip;
    logic [15:0]        r_hnew;
    logic signed [33:0] r_dx, r_dy;
    logic signed [31:0] r_x, r_y;
    logic [15:0]        r_h;

    logic signed [16:0] sum17, dif17;
    logic [16:0]        absd;
    logic signed [33:0] mul_a;
    logic signed [34:0] mul_b;
    logic signed [68:0] mul_p;
    logic [31:0]        div_d;
    logic [32:0]        div_t;
    logic               div_ge;
    logic [63:0]        p64;
    logic [31:0]        turn_m, half_m;
    logic [31:0]        h32, ang;
    logic               flip;
    logic [31:0]        hsum;
    logic [4:0]         sh;
    logic signed [33:0] xs, ys, at;
    logic signed [33:0] sx, sy;

    assign sum17 = 17'(r_l) + 17'(r_r);
    assign dif17 = 17'(r_r) - 17'(r_l);
    assign absd  = dif17[16] ? 17'(-dif17) : 17'(dif17);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_op)
            MUL_SUM: begin
                mul_a = 34'(sum17);
                mul_b = {3'b0, r_mpc};
            end
            MUL_DIFF: begin
                mul_a = {17'b0, absd};
                mul_b = {3'b0, r_mpc};
            end
            MUL_PLO: begin
                mul_a = {6'b0, r_qsh[27:0]};
                mul_b = {4'b0, INV_PI_Q32};
            end
            MUL_PHI: begin
                mul_a = {6'b0, r_qsh[55:28]};
                mul_b = {4'b0, INV_PI_Q32};
            end
            MUL_X: begin
                mul_a = 34'(r_dist);
                mul_b = 35'(r_cx);
            end
            MUL_Y: begin
                mul_a = 34'(r_dist);
                mul_b = 35'(r_cy);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Restoring division, one quotient bit a cycle; zero axle acts as one.
    assign div_d  = (r_axle == '0) ? 32'd1 : r_axle;
    assign div_t  = {r_rem, r_qsh[55]};
    assign div_ge = div_t >= {1'b0, div_d};

    assign p64    = r_plo + {r_phi, 28'b0};
    assign turn_m = p64[56:25];
    assign half_m = p64[57:26];

    assign h32  = {r_h, 16'b0};
    assign ang  = h32 + r_half;
    assign flip = ang[31] ^ ang[30];
    assign hsum = h32 + r_turn + 32'h8000;

    assign sh = i_cmd.idx[4:0];
    assign xs = r_cx >>> sh;
    assign ys = r_cy >>> sh;
    assign at = {4'b0, atan_bam(sh)};

    assign sx = 34'(r_x) + r_dx;
    assign sy = 34'(r_y) + r_dy;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] s;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            s = v[31:0];
        end else if (v[33]) begin
            s = 32'sh8000_0000;
        end else begin
            s = 32'sh7FFF_FFFF;
        end
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpc  <= MPC_RST;
            r_axle <= AXLE_RST;
            r_x    <= '0;
            r_y    <= '0;
            r_h    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MPC:  r_mpc  <= i_cfg_data;
                    REG_AXLE: r_axle <= i_cfg_data;
                    default:  r_mpc  <= r_mpc;
                endcase
            end
            if (i_cmd.update) begin
                r_x <= sat32(sx);
                r_y <= sat32(sy);
                r_h <= r_hnew;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_l <= i_left_counts;
            r_r <= i_right_counts;
        end
        case (i_cmd.mul_op)
            MUL_SUM: r_dist <= mul_p[49:17];
            MUL_DIFF: begin
                r_neg <= dif17[16];
                r_qsh <= {mul_p[47:0], 8'b0};
                r_rem <= '0;
            end
            MUL_PLO: r_plo <= mul_p[63:0];
            MUL_PHI: r_phi <= mul_p[35:0];
            MUL_X:   r_dx  <= mul_p[63:30];
            MUL_Y:   r_dy  <= mul_p[63:30];
            default: r_dist <= r_dist;
        endcase
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? 32'(div_t - {1'b0, div_d}) : div_t[31:0];
            r_qsh <= {r_qsh[54:0], div_ge};
        end
        if (i_cmd.turn) begin
            r_turn <= r_neg ? 32'(-turn_m) : turn_m;
            r_half <= r_neg ? 32'(-half_m) : half_m;
        end
        if (i_cmd.cordic_init) begin
            r_cz   <= 34'($signed({ang[31] ^ flip, ang[30:0]}));
            r_cx   <= CORDIC_GAIN;
            r_cy   <= '0;
            r_flip <= flip;
            r_hnew <= hsum[31:16];
        end
        if (i_cmd.cordic_step) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - at;
            end else begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + at;
            end
        end
        if (i_cmd.cordic_fix && r_flip) begin
            r_cx <= -r_cx;
            r_cy <= -r_cy;
        end
    end

    assign o_x_pos   = r_x;
    assign o_y_pos   = r_y;
    assign o_heading = r_h;

endmodule

>>> rtl/diff_drive_odometry_top.sv
// ============================================================================
// Differential-drive odometry top level
// Dead-reckoning pose integrator for a two-wheeled robot.
// ============================================================================
// Each input transaction carries the signed encoder counts of both wheels for
// one interval; the block turns them into a traveled distance and a turn
// angle, moves x and y along the heading plus half the turn, adds the turn to
// the heading and returns one transaction with the new saturated pose. The
// work of a transaction runs through the one-bit-per-cycle turn divider, one
// step per CORDIC stage (16 by default, at most 24 are used), and steps of
// the shared multiplier and bookkeeping. One transaction is worked on at a
// time; the result sits in the pose registers, so the next input can be
// taken while it still waits downstream. Configuration writes must only be
// issued while the block is idle.
module diff_drive_odometry_top #(
    parameter int CORDIC_STAGES = odo_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [odo_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [odo_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [odo_pkg::CNT_W-1:0]  i_left_counts,
    input  logic signed [odo_pkg::CNT_W-1:0]  i_right_counts,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [odo_pkg::DATA_W-1:0] o_x_pos,
    output logic signed [odo_pkg::DATA_W-1:0] o_y_pos,
    output logic signed [odo_pkg::HEAD_W-1:0] o_heading
);
    import odo_pkg::*;

    t_cmd cmd;

    // The controller owns the handshake and the step counter.
    odo_ctrl #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // The datapath holds configuration, pose accumulators and all arithmetic.
    odo_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_left_counts  (i_left_counts),
        .i_right_counts (i_right_counts),
        .o_x_pos        (o_x_pos),
        .o_y_pos        (o_y_pos),
        .o_heading      (o_heading)
    );

    // The block goes busy right after it takes a transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // A new result only appears at the end of a busy period.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work");

    // The pose never changes while a result waits downstream.
    a_pose_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_x_pos) && $stable(o_y_pos)
        && $stable(o_heading)))
        else $error("pose changed under stall");

endmodule
